>>> rtl/cned_pkg.sv
// ----------------------------------------------------------------------------
// cned_pkg
// Shared types and constants for the chord note event differ.
// ----------------------------------------------------------------------------
package cned_pkg;

  localparam int unsigned NOTE_W   = 7;
  localparam int unsigned CHAN_W   = 5;
  localparam int unsigned VEL_W    = 7;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned DEG_W    = 3;
  localparam int unsigned BASS_W   = 8;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned IN_NOTES = 7;

  localparam logic [BASS_W-1:0] NO_BASS      = 8'd128;
  localparam logic [CHAN_W-1:0] BASS_CHANNEL = 5'd2;
  localparam logic [DEG_W-1:0]  BAD_DEGREE   = 3'd7;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PRESS   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REVOICE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

  // Scan phases, in emission order
  typedef enum logic [1:0] {
    PH_OFF_NOTES,
    PH_OFF_BASS,
    PH_ON_NOTES,
    PH_ON_BASS
  } phase_e;

  typedef struct packed {
    logic             is_on;
    logic [CHAN_W-1:0] chan;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
  } event_t;

  // Controller to datapath
  typedef struct packed {
    logic             load;
    logic             step;
    logic             finish;
    phase_e           phase;
    logic [CNT_W-1:0] idx;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/cned_ctrl.sv
// ----------------------------------------------------------------------------
// cned_ctrl
// Sequencer: walks a request's four event phases one step a cycle when output is free.
// ----------------------------------------------------------------------------
module cned_ctrl
  import cned_pkg::*;
#(
  parameter int unsigned MAX_TONES = 7
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MAX_TONES - 1);

  state_e           state_q, state_d;
  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] idx_q, idx_d;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    idx_d      = idx_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.phase = phase_q;
    cmd_o.idx   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          phase_d    = PH_OFF_NOTES;
          idx_d      = '0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.out_free) begin
          cmd_o.step = 1'b1;
          // note phases run MAX_TONES steps, bass phases one
          if ((phase_q == PH_OFF_NOTES || phase_q == PH_ON_NOTES) && idx_q != LAST_IDX) begin
            idx_d = idx_q + 1'b1;
          end else begin
            idx_d = '0;
            unique case (phase_q)
              PH_OFF_NOTES: phase_d = PH_OFF_BASS;
              PH_OFF_BASS:  phase_d = PH_ON_NOTES;
              PH_ON_NOTES:  phase_d = PH_ON_BASS;
              PH_ON_BASS:   state_d = ST_FINISH;
              default:      state_d = ST_FINISH;
            endcase
          end
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_OFF_NOTES;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
    end
  end

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.step, cmd_o.finish}))
    else $error("more than one datapath command at once");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LAST_IDX)
    else $error("step index beyond tone count");

  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> in_ready_o)
    else $error("finish did not return to idle");

endmodule

>>> rtl/cned_dp.sv
// ----------------------------------------------------------------------------
// cned_dp
// Datapath: request latch, held chord, event compare, pending and output regs.
// ----------------------------------------------------------------------------
module cned_dp
  import cned_pkg::*;
#(
  parameter int unsigned MAX_TONES = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_cmd_t               cmd_i,
  output dp_status_t              status_o,
  // request fields
  input  logic [REQ_W-1:0]        req_type_i,
  input  logic [DEG_W-1:0]        degree_i,
  input  logic [VEL_W-1:0]        velocity_i,
  input  logic [CNT_W-1:0]        note_count_i,
  input  logic [IN_NOTES*NOTE_W-1:0] notes_i,
  input  logic [BASS_W-1:0]       bass_note_i,
  // channel register write
  input  logic                    cfg_we_i,
  input  logic [CHAN_W-1:0]       cfg_data_i,
  // event output
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output event_t                  out_event_o,
  output logic                    out_last_o
);

  localparam int unsigned IDX_W = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TONES);

  // latched request
  logic [REQ_W-1:0]  req_q;
  logic [DEG_W-1:0]  deg_q;
  logic [VEL_W-1:0]  vel_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [NOTE_W-1:0] notes_q [IN_NOTES];
  logic [BASS_W-1:0] bass_q;

  // held chord
  logic              active_q;
  logic [CNT_W-1:0]  held_count_q;
  logic [BASS_W-1:0] held_bass_q;
  logic [DEG_W-1:0]  held_deg_q;
  logic [VEL_W-1:0]  held_vel_q;
  logic [CHAN_W-1:0] held_chan_q;
  logic [NOTE_W-1:0] held_notes_q [MAX_TONES];
  logic [CHAN_W-1:0] harmony_chan_q;

  // pending event and output register
  logic   pend_valid_q;
  event_t pend_q;
  logic   out_valid_q;
  event_t out_q;
  logic   out_last_q;

  logic              noop;
  logic [NOTE_W-1:0] cur_held, cur_new;
  logic              in_new, in_held, idx_in_held, idx_in_new, bass_changed;
  logic              emit;
  event_t            ev;
  logic              push, commit;
  logic              out_free;

  assign out_free          = !out_valid_q || out_ready_i;
  assign status_o.out_free = out_free;

  always_comb begin
    unique case (req_q)
      REQ_PRESS:   noop = (deg_q == BAD_DEGREE) || (active_q && held_deg_q == deg_q)
                          || (cnt_q == '0);
      REQ_REVOICE: noop = !active_q;
      REQ_RELEASE: noop = !active_q;
      default:     noop = 1'b1;
    endcase
  end

  assign cur_held     = held_notes_q[cmd_i.idx[IDX_W-1:0]];
  assign cur_new      = notes_q[cmd_i.idx];
  assign idx_in_held  = cmd_i.idx < held_count_q;
  assign idx_in_new   = cmd_i.idx < cnt_q;
  assign bass_changed = held_bass_q != bass_q;

  always_comb begin
    in_new = 1'b0;
    for (int j = 0; j < IN_NOTES; j++) begin
      if (CNT_W'(j) < cnt_q && notes_q[j] == cur_held) in_new = 1'b1;
    end
  end

  always_comb begin
    in_held = 1'b0;
    for (int j = 0; j < MAX_TONES; j++) begin
      if (CNT_W'(j) < held_count_q && held_notes_q[j] == cur_new) in_held = 1'b1;
    end
  end

  always_comb begin
    ev = '0;
    unique case (cmd_i.phase)
      PH_OFF_NOTES: begin
        emit    = active_q && idx_in_held && (req_q != REQ_REVOICE || !in_new);
        ev.chan = held_chan_q;
        ev.note = cur_held;
      end
      PH_OFF_BASS: begin
        emit    = !held_bass_q[BASS_W-1] && (req_q != REQ_REVOICE || bass_changed);
        ev.chan = BASS_CHANNEL;
        ev.note = held_bass_q[NOTE_W-1:0];
      end
      PH_ON_NOTES: begin
        ev.is_on = 1'b1;
        ev.note  = cur_new;
        if (req_q == REQ_PRESS) begin
          emit    = idx_in_new;
          ev.chan = harmony_chan_q;
          ev.vel  = vel_q;
        end else begin
          emit    = idx_in_new && req_q == REQ_REVOICE && !in_held;
          ev.chan = held_chan_q;
          ev.vel  = held_vel_q;
        end
      end
      PH_ON_BASS: begin
        ev.is_on = 1'b1;
        ev.chan  = BASS_CHANNEL;
        ev.note  = bass_q[NOTE_W-1:0];
        ev.vel   = (req_q == REQ_PRESS) ? vel_q : held_vel_q;
        emit     = !bass_q[BASS_W-1] &&
                   (req_q == REQ_PRESS || (req_q == REQ_REVOICE && bass_changed));
      end
      default: emit = 1'b0;
    endcase
    emit = emit && !noop && cmd_i.step;
  end

  // the pending event goes out once the next one exists, or at finish with last set
  assign push   = pend_valid_q && (emit || cmd_i.finish);
  assign commit = cmd_i.finish && !noop;

  // request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      deg_q  <= degree_i;
      vel_q  <= velocity_i;
      cnt_q  <= (note_count_i > MAX_CNT) ? MAX_CNT : note_count_i;
      bass_q <= bass_note_i[BASS_W-1] ? NO_BASS : bass_note_i;
      for (int i = 0; i < IN_NOTES; i++) begin
        notes_q[i] <= notes_i[i*NOTE_W +: NOTE_W];
      end
    end
  end

  // held chord payload, no reset
  always_ff @(posedge clk_i) begin
    if (commit) begin
      if (req_q == REQ_PRESS) begin
        held_deg_q  <= deg_q;
        held_vel_q  <= vel_q;
        held_chan_q <= harmony_chan_q;
      end
      if (req_q == REQ_PRESS || req_q == REQ_REVOICE) begin
        for (int i = 0; i < MAX_TONES; i++) begin
          held_notes_q[i] <= notes_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) pend_q <= ev;
    if (push) begin
      out_q      <= pend_q;
      out_last_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q       <= 1'b0;
      held_count_q   <= '0;
      held_bass_q    <= NO_BASS;
      harmony_chan_q <= CHAN_W'(1);
      pend_valid_q   <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) harmony_chan_q <= cfg_data_i;
      if (commit) begin
        unique case (req_q)
          REQ_PRESS, REQ_REVOICE: begin
            active_q     <= 1'b1;
            held_count_q <= cnt_q;
            held_bass_q  <= bass_q;
          end
          REQ_RELEASE: begin
            active_q     <= 1'b0;
            held_count_q <= '0;
            held_bass_q  <= NO_BASS;
          end
          default: ;
        endcase
      end
      if (emit)              pend_valid_q <= 1'b1;
      else if (cmd_i.finish) pend_valid_q <= 1'b0;
      if (push)              out_valid_q <= 1'b1;
      else if (out_ready_i)  out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_event_o = out_q;
  assign out_last_o  = out_last_q;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("event pushed over an untaken one");

  a_pend_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> !pend_valid_q)
    else $error("pending event left after finish");

  a_idle_chord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (held_count_q == '0 && held_bass_q == NO_BASS))
    else $error("inactive chord still holds notes");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_count_q <= MAX_CNT)
    else $error("held count above tone limit");

endmodule

>>> rtl/chord_note_event_differ.sv
// ----------------------------------------------------------------------------
// chord_note_event_differ
// Holds one sounding chord and turns press, revoice and release requests
// into a serial stream of note-on and note-off events.
// ----------------------------------------------------------------------------
//  channel   direction  tdata (low bit up)                          tuser / tlast
//  s_axis    in         degree, velocity, note_count, note_a..g,    tuser: req_type
//                       bass_note, 2 zero bits (72 bits)
//  m_axis    out        channel, note_number, event_velocity,       tuser: is_note_on
//                       5 zero bits (24 bits)                       tlast: last_event
//  cfg       in         harmony_channel (5 bits), always ready
//
//  Walk: after accept the sequencer visits every held and every new note
//  slot plus both bass slots once before it is ready again. Requests that
//  cause no event run the same walk.
//  Reset: asynchronous, low active; clears the chord to inactive, no notes,
//  no bass, and the harmony channel to 1.
//  Stalls: events go out through a one-deep output register behind a
//  one-event pending stage; the walk holds while the output register is full
//  and not taken, so no event is dropped.
// ----------------------------------------------------------------------------
module chord_note_event_differ
  import cned_pkg::*;
#(
  parameter int unsigned MAX_TONES = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // degree, velocity, note_count, note_a..note_g, bass_note
  input  logic [1:0]  s_axis_tuser_i,   // req_type
  // event stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // channel, note_number, event_velocity
  output logic        m_axis_tuser_o,   // is_note_on
  output logic        m_axis_tlast_o,   // last_event
  // harmony channel register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;
  event_t     out_event;

  cned_ctrl #(
    .MAX_TONES (MAX_TONES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cned_dp #(
    .MAX_TONES (MAX_TONES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .req_type_i   (s_axis_tuser_i),
    .degree_i     (s_axis_tdata_i[2:0]),
    .velocity_i   (s_axis_tdata_i[9:3]),
    .note_count_i (s_axis_tdata_i[12:10]),
    .notes_i      (s_axis_tdata_i[61:13]),
    .bass_note_i  (s_axis_tdata_i[69:62]),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_event_o  (out_event),
    .out_last_o   (m_axis_tlast_o)
  );

  // the register takes a write in any cycle
  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = in_ready;
  assign m_axis_tuser_o  = out_event.is_on;
  assign m_axis_tdata_o  = {5'd0, out_event.vel, out_event.note, out_event.chan};

endmodule
